@@ hdl/ctfgi_pkg.sv @@
// Shared constants, register codes and types for the coarse-to-fine grid index block.
`default_nettype none
package ctfgi_pkg;

    localparam int IDX_W     = 31;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIMCNT_W  = 3;
    localparam int BIT_CNT_W = 5;

    localparam logic [IDX_W-1:0] IDX_LIMIT = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_SIZES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SIZES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_TOTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_TOTAL   = 3'd4;

    localparam logic [DIMCNT_W-1:0] RST_DIM_COUNT = 3'd4;
    localparam logic [CFG_W-1:0]    RST_SIZES     = 64'h0002_0002_0002_0002;
    localparam logic [IDX_W-1:0]    RST_TOTAL     = 31'd16;

    // Per-slot constants derived from the configuration
    typedef struct packed {
        logic             active;
        logic             skip;
        logic [IDX_W-1:0] cdiv;
        logic [IDX_W-1:0] fdiv;
    } t_slot_cfg;

endpackage
`default_nettype wire

@@ hdl/ctfgi_div_cell.sv @@
// One restoring-division step cell: consumes one dividend bit, passes a sideband along.
`default_nettype none
module ctfgi_div_cell #(
    parameter int NW = 31,
    parameter int DW = 31,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);

    logic [DW:0]   w_tmp;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [NW-1:0] n_num;
    logic [DW-1:0] n_rem;
    logic          r_valid;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [PW-1:0] r_pay;

    assign w_tmp  = {i_rem, i_num[NW-1]};
    assign w_ge   = w_tmp >= {1'b0, i_den};
    assign w_diff = w_tmp - {1'b0, i_den};
    assign n_rem  = w_ge ? w_diff[DW-1:0] : w_tmp[DW-1:0];
    // dividend shifts out at the top, quotient bits shift in at the bottom
    assign n_num  = {i_num[NW-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_pay <= i_pay;
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_pay   = r_pay;

endmodule
`default_nettype wire

@@ hdl/ctfgi_dim_slot.sv @@
// One dimension slot: coordinate split, rescale and index accumulation as a cell chain.
`default_nettype none
module ctfgi_dim_slot #(
    parameter int SB = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ctfgi_pkg::t_slot_cfg     i_cfg,
    input  logic [SB-1:0]            i_nc_m1,
    input  logic [SB-1:0]            i_nf_m1,
    input  logic                     i_valid,
    input  logic                     i_err,
    input  logic [ctfgi_pkg::IDX_W-1:0] i_rest,
    input  logic [ctfgi_pkg::IDX_W-1:0] i_idx,
    output logic                     o_valid,
    output logic                     o_err,
    output logic [ctfgi_pkg::IDX_W-1:0] o_rest,
    output logic [ctfgi_pkg::IDX_W-1:0] o_idx
);

    localparam int W  = ctfgi_pkg::IDX_W;
    localparam int NB = W + SB;
    localparam int PA = W + 1;
    localparam int PB = 2 * W + 1;

    // coordinate split: rest / cdiv
    logic          a_v   [0:W];
    logic [W-1:0]  a_num [0:W];
    logic [W-1:0]  a_rem [0:W];
    logic [PA-1:0] a_pay [0:W];

    assign a_v[0]   = i_valid;
    assign a_num[0] = i_rest;
    assign a_rem[0] = '0;
    assign a_pay[0] = {i_err, i_idx};

    for (genvar g = 0; g < W; g++) begin : g_split
        ctfgi_div_cell #(.NW(W), .DW(W), .PW(PA)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (a_v[g]),
            .i_num   (a_num[g]),
            .i_rem   (a_rem[g]),
            .i_den   (i_cfg.cdiv),
            .i_pay   (a_pay[g]),
            .o_valid (a_v[g+1]),
            .o_num   (a_num[g+1]),
            .o_rem   (a_rem[g+1]),
            .o_pay   (a_pay[g+1])
        );
    end

    // coordinate times (fine - 1)
    logic          r_m_v;
    logic [NB-1:0] r_m_prod;
    logic [PB-1:0] r_m_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= a_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod <= NB'(a_num[W]) * NB'(i_nf_m1);
        r_m_pay  <= {a_pay[W], a_rem[W]};
    end

    // rescale: product / (coarse - 1)
    logic          b_v   [0:NB];
    logic [NB-1:0] b_num [0:NB];
    logic [SB-1:0] b_rem [0:NB];
    logic [PB-1:0] b_pay [0:NB];

    assign b_v[0]   = r_m_v;
    assign b_num[0] = r_m_prod;
    assign b_rem[0] = '0;
    assign b_pay[0] = r_m_pay;

    for (genvar g = 0; g < NB; g++) begin : g_scale
        ctfgi_div_cell #(.NW(NB), .DW(SB), .PW(PB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_v[g]),
            .i_num   (b_num[g]),
            .i_rem   (b_rem[g]),
            .i_den   (i_nc_m1),
            .i_pay   (b_pay[g]),
            .o_valid (b_v[g+1]),
            .o_num   (b_num[g+1]),
            .o_rem   (b_rem[g+1]),
            .o_pay   (b_pay[g+1])
        );
    end

    // term = scaled * fine stride
    logic           r_t_v;
    logic           r_t_ovf;
    logic [2*W-1:0] r_t_term;
    logic [PB-1:0]  r_t_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else begin
            r_t_v <= b_v[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_ovf  <= |b_num[NB][NB-1:W];
        r_t_term <= (2*W)'(b_num[NB][W-1:0]) * (2*W)'(i_cfg.fdiv);
        r_t_pay  <= b_pay[NB];
    end

    // accumulate and check
    logic         w_t_err;
    logic [W-1:0] w_t_idx;
    logic [W-1:0] w_t_rest;
    logic         w_use;
    logic [2*W:0] w_sum;
    logic         w_bad;
    logic         n_err;
    logic [W-1:0] n_idx;
    logic         r_s_v;
    logic         r_s_err;
    logic [W-1:0] r_s_idx;
    logic [W-1:0] r_s_rest;

    assign w_t_err  = r_t_pay[2*W];
    assign w_t_idx  = r_t_pay[2*W-1:W];
    assign w_t_rest = r_t_pay[W-1:0];
    // a coarse size of one contributes nothing
    assign w_use    = i_cfg.active & ~i_cfg.skip;
    assign w_sum    = (2*W+1)'(r_t_term) + (2*W+1)'(w_t_idx);
    // zero fine stride wins over a too-large scaled coordinate
    assign w_bad    = (r_t_ovf & (i_cfg.fdiv != '0)) | (|w_sum[2*W:W]);
    assign n_err    = w_t_err | (w_use & w_bad);
    assign n_idx    = w_use ? w_sum[W-1:0] : w_t_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_err  <= n_err;
        r_s_idx  <= n_idx;
        r_s_rest <= w_t_rest;
    end

    assign o_valid = r_s_v;
    assign o_err   = r_s_err;
    assign o_rest  = r_s_rest;
    assign o_idx   = r_s_idx;

endmodule
`default_nettype wire

@@ hdl/ctfgi_setup.sv @@
// Sequential derivation of per-slot divisors and strides after reset or a register write.
`default_nettype none
module ctfgi_setup #(
    parameter int MAX_DIM = 4,
    parameter int SB      = 16,
    parameter int DCW     = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_kick,
    input  logic [DCW-1:0]              i_dims,
    input  logic [SB-1:0]               i_coarse_f [MAX_DIM],
    input  logic [SB-1:0]               i_fine_f   [MAX_DIM],
    input  logic [ctfgi_pkg::IDX_W-1:0] i_coarse_total,
    input  logic [ctfgi_pkg::IDX_W-1:0] i_fine_total,
    output logic                        o_busy,
    output logic                        o_err,
    output ctfgi_pkg::t_slot_cfg        o_cfg   [MAX_DIM],
    output logic [SB-1:0]               o_nc_m1 [MAX_DIM],
    output logic [SB-1:0]               o_nf_m1 [MAX_DIM]
);

    localparam int W  = ctfgi_pkg::IDX_W;
    localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int BW = ctfgi_pkg::BIT_CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                r_state;
    logic [DCW-1:0]      r_k;
    logic [BW-1:0]       r_bit;
    logic                r_err;
    logic [MAX_DIM-1:0]  r_active;
    logic [MAX_DIM-1:0]  r_skip;
    logic [W-1:0]        r_cdiv  [MAX_DIM];
    logic [W-1:0]        r_fdiv  [MAX_DIM];
    logic [SB-1:0]       r_nc_m1 [MAX_DIM];
    logic [SB-1:0]       r_nf_m1 [MAX_DIM];
    logic [W-1:0]        r_qc;
    logic [W-1:0]        r_qf;
    logic [SB-1:0]       r_rc;
    logic [SB-1:0]       r_rf;

    logic [DCW-1:0] w_jfull;
    logic [KW-1:0]  w_j;
    logic [KW-1:0]  w_k;
    logic [SB-1:0]  w_nc;
    logic [SB-1:0]  w_nf;
    logic [SB:0]    w_tc;
    logic [SB:0]    w_tf;
    logic           w_gc;
    logic           w_gf;
    logic [SB:0]    w_dc;
    logic [SB:0]    w_df;
    logic [W-1:0]   n_qc;
    logic [W-1:0]   n_qf;
    logic [SB-1:0]  n_rc;
    logic [SB-1:0]  n_rf;
    logic           w_last;

    // slot k handles dimension dims-1-k
    assign w_jfull = i_dims - DCW'(1) - r_k;
    assign w_j     = KW'(w_jfull);
    assign w_k     = KW'(r_k);
    assign w_nc    = i_coarse_f[w_j];
    assign w_nf    = i_fine_f[w_j];

    assign w_tc = {r_rc, r_qc[W-1]};
    assign w_tf = {r_rf, r_qf[W-1]};
    assign w_gc = w_tc >= {1'b0, w_nc};
    assign w_gf = w_tf >= {1'b0, w_nf};
    assign w_dc = w_tc - {1'b0, w_nc};
    assign w_df = w_tf - {1'b0, w_nf};
    assign n_rc = w_gc ? w_dc[SB-1:0] : w_tc[SB-1:0];
    assign n_rf = w_gf ? w_df[SB-1:0] : w_tf[SB-1:0];
    assign n_qc = {r_qc[W-2:0], w_gc};
    assign n_qf = {r_qf[W-2:0], w_gf};
    assign w_last = (r_bit == BW'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_bit    <= '0;
            r_err    <= 1'b0;
            r_active <= '0;
        end else if (i_kick) begin
            r_state  <= (i_dims == '0) ? ST_IDLE : ST_DIV;
            r_k      <= '0;
            r_bit    <= '0;
            r_err    <= 1'b0;
            r_active <= '0;
        end else if (r_state == ST_DIV) begin
            if (w_last) begin
                r_bit         <= '0;
                r_k           <= r_k + DCW'(1);
                r_active[w_k] <= 1'b1;
                r_err         <= r_err | (w_nc == '0) | (w_nf == '0) | (n_qc == '0);
                if (r_k == i_dims - DCW'(1)) begin
                    r_state <= ST_IDLE;
                end
            end else begin
                r_bit <= r_bit + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_kick) begin
            r_qc <= i_coarse_total;
            r_qf <= i_fine_total;
            r_rc <= '0;
            r_rf <= '0;
        end else if (r_state == ST_DIV) begin
            r_qc <= n_qc;
            r_qf <= n_qf;
            if (w_last) begin
                // quotient is the dividend of the next dimension
                r_rc         <= '0;
                r_rf         <= '0;
                r_cdiv[w_k]  <= n_qc;
                r_fdiv[w_k]  <= n_qf;
                r_nc_m1[w_k] <= w_nc - SB'(1);
                r_nf_m1[w_k] <= w_nf - SB'(1);
                r_skip[w_k]  <= (w_nc == SB'(1));
            end else begin
                r_rc <= n_rc;
                r_rf <= n_rf;
            end
        end
    end

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_out
        assign o_cfg[g].active = r_active[g];
        assign o_cfg[g].skip   = r_skip[g];
        assign o_cfg[g].cdiv   = r_cdiv[g];
        assign o_cfg[g].fdiv   = r_fdiv[g];
        assign o_nc_m1[g]      = r_nc_m1[g];
        assign o_nf_m1[g]      = r_nf_m1[g];
    end

    assign o_busy = (r_state == ST_DIV);
    assign o_err  = r_err;

endmodule
`default_nettype wire

@@ hdl/coarse_to_fine_grid_index.sv @@
// Top level: coarse grid point number to fine grid index converter.
// An accepted start passes one entry stage, per dimension two chains of one-bit
// division cells and three arithmetic stages, and one output stage before the strobe.
// Throughput: one transaction per cycle while busy is low; results come out in order
// and cannot be stalled. Reset and each register write run a setup pass with busy high.
`default_nettype none
module coarse_to_fine_grid_index #(
    parameter int MAX_DIM   = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ctfgi_pkg::IDX_W-1:0]     i_point_number,
    output logic                            o_result_valid,
    output logic [ctfgi_pkg::IDX_W-1:0]     o_fine_index,
    output logic                            o_range_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ctfgi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ctfgi_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int W   = ctfgi_pkg::IDX_W;
    localparam int SB  = SIZE_BITS;
    localparam int DCW = $clog2(MAX_DIM + 1);

    logic [ctfgi_pkg::DIMCNT_W-1:0] r_dim_count;
    logic [ctfgi_pkg::CFG_W-1:0]    r_coarse_sizes;
    logic [ctfgi_pkg::CFG_W-1:0]    r_fine_sizes;
    logic [W-1:0]                   r_coarse_total;
    logic [W-1:0]                   r_fine_total;
    logic                           r_kick;
    logic                           w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count    <= ctfgi_pkg::RST_DIM_COUNT;
            r_coarse_sizes <= ctfgi_pkg::RST_SIZES;
            r_fine_sizes   <= ctfgi_pkg::RST_SIZES;
            r_coarse_total <= ctfgi_pkg::RST_TOTAL;
            r_fine_total   <= ctfgi_pkg::RST_TOTAL;
            r_kick         <= 1'b1;
        end else begin
            r_kick <= w_cfg_wr;
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    ctfgi_pkg::REG_DIM_COUNT:
                        r_dim_count <= i_cfg_data[ctfgi_pkg::DIMCNT_W-1:0];
                    ctfgi_pkg::REG_COARSE_SIZES: r_coarse_sizes <= i_cfg_data;
                    ctfgi_pkg::REG_FINE_SIZES:   r_fine_sizes   <= i_cfg_data;
                    ctfgi_pkg::REG_COARSE_TOTAL: r_coarse_total <= i_cfg_data[W-1:0];
                    ctfgi_pkg::REG_FINE_TOTAL:   r_fine_total   <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // size fields; fields above bit 63 read as zero
    logic [SB-1:0]  w_cf [MAX_DIM];
    logic [SB-1:0]  w_ff [MAX_DIM];
    logic [DCW-1:0] w_dims;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_field
        assign w_cf[g] = SB'(r_coarse_sizes >> (SB * g));
        assign w_ff[g] = SB'(r_fine_sizes >> (SB * g));
    end

    assign w_dims = (int'(r_dim_count) > MAX_DIM) ? DCW'(MAX_DIM) : DCW'(r_dim_count);

    ctfgi_pkg::t_slot_cfg w_slot_cfg [MAX_DIM];
    logic [SB-1:0]        w_nc_m1    [MAX_DIM];
    logic [SB-1:0]        w_nf_m1    [MAX_DIM];
    logic                 w_setup_busy;
    logic                 w_cfg_err;

    ctfgi_setup #(.MAX_DIM(MAX_DIM), .SB(SB), .DCW(DCW)) u_setup (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kick         (r_kick),
        .i_dims         (w_dims),
        .i_coarse_f     (w_cf),
        .i_fine_f       (w_ff),
        .i_coarse_total (r_coarse_total),
        .i_fine_total   (r_fine_total),
        .o_busy         (w_setup_busy),
        .o_err          (w_cfg_err),
        .o_cfg          (w_slot_cfg),
        .o_nc_m1        (w_nc_m1),
        .o_nf_m1        (w_nf_m1)
    );

    assign busy = r_kick | w_setup_busy;

    // entry stage
    logic         r_e_v;
    logic         r_e_err;
    logic [W-1:0] r_e_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_rest <= i_point_number;
        r_e_err  <= (i_point_number >= r_coarse_total) | w_cfg_err;
    end

    logic         p_v    [0:MAX_DIM];
    logic         p_err  [0:MAX_DIM];
    logic [W-1:0] p_rest [0:MAX_DIM];
    logic [W-1:0] p_idx  [0:MAX_DIM];

    assign p_v[0]    = r_e_v;
    assign p_err[0]  = r_e_err;
    assign p_rest[0] = r_e_rest;
    assign p_idx[0]  = '0;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_slot
        ctfgi_dim_slot #(.SB(SB)) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_slot_cfg[g]),
            .i_nc_m1 (w_nc_m1[g]),
            .i_nf_m1 (w_nf_m1[g]),
            .i_valid (p_v[g]),
            .i_err   (p_err[g]),
            .i_rest  (p_rest[g]),
            .i_idx   (p_idx[g]),
            .o_valid (p_v[g+1]),
            .o_err   (p_err[g+1]),
            .o_rest  (p_rest[g+1]),
            .o_idx   (p_idx[g+1])
        );
    end

    // output stage, saturated on error
    logic         r_o_v;
    logic         r_o_err;
    logic [W-1:0] r_o_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= p_v[MAX_DIM];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_err <= p_err[MAX_DIM];
        r_o_idx <= p_err[MAX_DIM] ? ctfgi_pkg::IDX_LIMIT : p_idx[MAX_DIM];
    end

    assign o_result_valid = r_o_v;
    assign o_fine_index   = r_o_idx;
    assign o_range_error  = r_o_err;

endmodule
`default_nettype wire

@@ hdl/ctfgi_checker.sv @@
// Port-level checks for the grid index converter, bound to the top level.
`default_nettype none
module ctfgi_checker #(
    parameter int MAX_DIM = 4,
    parameter int SB      = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic                            o_result_valid,
    input logic [ctfgi_pkg::IDX_W-1:0]     o_fine_index,
    input logic                            o_range_error
);

    localparam int LAT = MAX_DIM * (65 + SB) + 2;

    // every transaction comes back after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("result missing after accepted transaction");

    // no result without a transaction behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted transaction");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_range_error) |-> (o_fine_index == ctfgi_pkg::IDX_LIMIT))
        else $error("error result not saturated");

    // register write starts a setup pass
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> busy)
        else $error("busy not raised after register write");

endmodule

bind coarse_to_fine_grid_index ctfgi_checker #(
    .MAX_DIM (MAX_DIM),
    .SB      (SIZE_BITS)
) u_ctfgi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready),
    .o_result_valid (o_result_valid),
    .o_fine_index   (o_fine_index),
    .o_range_error  (o_range_error)
);
`default_nettype wire
